>>> rtl/core/mpus_pkg.sv
`default_nettype none

package mpus_pkg;

   localparam int REG_BYTES   = 24;
   localparam int PAT_IDX_W   = 5;
   localparam int LENGTH_W    = 5;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int ADDR_W      = 64;
   localparam int STATUS_W    = 2;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 72;
   localparam int RSP_PAD_W   = RSP_DATA_W - ADDR_W - STATUS_W;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_UNIQUE = 2'd0,
      STATUS_NONE   = 2'd1,
      STATUS_MULTI  = 2'd2,
      STATUS_WILD   = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_0   = 3'd0,
      CSR_PATTERN_1   = 3'd1,
      CSR_PATTERN_2   = 3'd2,
      CSR_CARE_BITS   = 3'd3,
      CSR_PATTERN_LEN = 3'd4,
      CSR_REGION_BASE = 3'd5
   } csr_index_type;

endpackage

`default_nettype wire

>>> rtl/core/masked_pattern_unique_scan.sv
// Wildcard byte pattern search over a streamed memory region.
// Bytes of the region arrive on the req_ channel, one per transaction, in
// address order; req_tlast marks the final byte. Each byte enters a
// sliding window, and every window that starts at a multiple of
// START_STRIDE and fits inside the region is compared with the pattern,
// honouring the per-byte care bits. On the final byte one transaction
// leaves on the rsp_ channel: unique match with its address, no match,
// several matches, or an all-wildcard pattern.
// The block takes one byte per cycle unless a waiting result stalls it. A
// byte is registered into the window on the edge that accepts it and is
// compared there; the result is then loaded into the output register.
// The full masked compare of the window is the single stage that sets this
// rate. Reset clears the scan counters and the output valid flag and loads
// the configuration registers with their reset values. If the receiver
// stalls while a result waits, bytes keep flowing until another final byte
// reaches the compare stage, which then holds req_tready low until the
// result is taken. The user must write the csr_ port only while no region
// is in progress; the block itself does not enforce this.
`default_nettype none

module masked_pattern_unique_scan
   import mpus_pkg::*;
#(
   parameter int PATTERN_MAX  = 24,
   parameter int START_STRIDE = 4,
   parameter int OFFSET_BITS  = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,   // data_byte
   input  wire logic                   req_tlast,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,   // status, match_address, zero fill
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int LEN_W   = $clog2(PATTERN_MAX + 1);
   localparam int PHASE_W = (START_STRIDE > 1) ? $clog2(START_STRIDE) : 1;

   logic [REG_BYTES*8-1:0]   pattern_ff, pattern_in;
   logic [REG_BYTES-1:0]     care_ff, care_in;
   logic [LENGTH_W-1:0]      length_ff, length_in;
   logic [ADDR_W-1:0]        base_ff, base_in;

   logic [7:0]               window_ff [PATTERN_MAX];
   logic [7:0]               window_in [PATTERN_MAX];
   logic [OFFSET_BITS-1:0]   bytes_seen_ff, bytes_seen_in;
   logic [PHASE_W-1:0]       phase_ff, phase_in;
   logic                     restart_ff, restart_in;

   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_last_ff, s1_last_in;
   logic                     s1_test_ff, s1_test_in;
   logic [OFFSET_BITS-1:0]   s1_taken_ff, s1_taken_in;
   logic [PHASE_W-1:0]       s1_phase_ff, s1_phase_in;

   logic [1:0]               match_count_ff, match_count_in;
   logic [OFFSET_BITS-1:0]   first_offset_ff, first_offset_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]        rsp_addr_ff, rsp_addr_in;

   logic                     advance;
   logic                     req_take;
   logic                     s2_fire;
   logic [OFFSET_BITS-1:0]   seen_base;
   logic [PHASE_W-1:0]       phase_base;
   logic [LEN_W-1:0]         len_sel;
   logic [PHASE_W-1:0]       len_phase;
   logic [PATTERN_MAX-1:0]   aligned_care;
   logic [7:0]               aligned_byte [PATTERN_MAX];
   logic [PATTERN_MAX-1:0]   mismatch;
   logic                     all_wild;
   logic                     hit;
   logic [OFFSET_BITS-1:0]   start_offset;
   logic [1:0]               count_upd;
   logic [OFFSET_BITS-1:0]   first_upd;

   // Configuration registers.
   always_comb begin
      pattern_in = pattern_ff;
      care_in    = care_ff;
      length_in  = length_ff;
      base_in    = base_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_PATTERN_0:   pattern_in[0 +: 64]   = csr_data;
            CSR_PATTERN_1:   pattern_in[64 +: 64]  = csr_data;
            CSR_PATTERN_2:   pattern_in[128 +: 64] = csr_data;
            CSR_CARE_BITS:   care_in   = csr_data[REG_BYTES-1:0];
            CSR_PATTERN_LEN: length_in = csr_data[LENGTH_W-1:0];
            CSR_REGION_BASE: base_in   = csr_data;
            default: ;
         endcase
      end
   end

   // Input stage: window shift and byte counting.
   always_comb begin
      advance    = !s1_valid_ff || !s1_last_ff || !rsp_valid_ff || rsp_tready;
      req_tready = advance;
      req_take   = req_tvalid && advance;

      seen_base  = restart_ff ? '0 : bytes_seen_ff;
      phase_base = restart_ff ? '0 : phase_ff;

      window_in     = window_ff;
      bytes_seen_in = bytes_seen_ff;
      phase_in      = phase_ff;
      restart_in    = restart_ff;
      s1_valid_in   = s1_valid_ff && !advance;
      s1_last_in    = s1_last_ff;
      s1_test_in    = s1_test_ff;
      s1_taken_in   = s1_taken_ff;
      s1_phase_in   = s1_phase_ff;

      if (req_take) begin
         window_in[0] = req_tdata;
         for (int k = 1; k < PATTERN_MAX; k++) begin
            window_in[k] = window_ff[k-1];
         end
         restart_in  = req_tlast;
         s1_valid_in = 1'b1;
         s1_last_in  = req_tlast;
         s1_test_in  = !(&seen_base);
         s1_taken_in = seen_base + OFFSET_BITS'(1);
         s1_phase_in = (phase_base == PHASE_W'(START_STRIDE - 1)) ? '0
                                                                  : phase_base + PHASE_W'(1);
         if (!(&seen_base)) begin
            bytes_seen_in = s1_taken_in;
            phase_in      = s1_phase_in;
         end else begin
            bytes_seen_in = seen_base;
            phase_in      = phase_base;
         end
      end
   end

   // Compare stage: pattern aligned to the window, masked compare, counting.
   always_comb begin
      int p;
      logic [PAT_IDX_W-1:0] pi;

      if (int'(length_ff) > PATTERN_MAX) begin
         len_sel = LEN_W'(PATTERN_MAX);
      end else begin
         len_sel = LEN_W'(length_ff);
      end

      len_phase = '0;
      for (int j = 0; j <= PATTERN_MAX; j++) begin
         if (len_sel == LEN_W'(j)) begin
            len_phase = PHASE_W'(j % START_STRIDE);
         end
      end

      for (int j = 0; j < PATTERN_MAX; j++) begin
         p  = int'(len_sel) - 1 - j;
         pi = p[PAT_IDX_W-1:0];
         if (p >= 0 && p < REG_BYTES) begin
            aligned_care[j] = care_ff[pi];
            aligned_byte[j] = pattern_ff[{pi, 3'b000} +: 8];
         end else begin
            aligned_care[j] = 1'b0;
            aligned_byte[j] = '0;
         end
         mismatch[j] = aligned_care[j] && (window_ff[j] != aligned_byte[j]);
      end

      all_wild     = ~|aligned_care;
      start_offset = s1_taken_ff - OFFSET_BITS'(len_sel);
      hit = s1_test_ff && (len_sel != '0) && (s1_taken_ff >= OFFSET_BITS'(len_sel))
            && (s1_phase_ff == len_phase) && ~|mismatch;

      count_upd = match_count_ff;
      first_upd = first_offset_ff;
      if (hit) begin
         if (match_count_ff == 2'd0) begin
            first_upd = start_offset;
         end
         if (match_count_ff != 2'd2) begin
            count_upd = match_count_ff + 2'd1;
         end
      end

      s2_fire = s1_valid_ff && advance;

      match_count_in  = match_count_ff;
      first_offset_in = first_offset_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_status_in   = rsp_status_ff;
      rsp_addr_in     = rsp_addr_ff;

      if (s2_fire) begin
         if (s1_last_ff) begin
            match_count_in  = '0;
            first_offset_in = '0;
            rsp_valid_in    = 1'b1;
            rsp_addr_in     = '0;
            priority if (all_wild) begin
               rsp_status_in = STATUS_WILD;
            end else if (count_upd == 2'd0) begin
               rsp_status_in = STATUS_NONE;
            end else if (count_upd == 2'd1) begin
               rsp_status_in = STATUS_UNIQUE;
               rsp_addr_in   = base_ff + ADDR_W'(first_upd);
            end else begin
               rsp_status_in = STATUS_MULTI;
            end
         end else begin
            match_count_in  = count_upd;
            first_offset_in = first_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff      <= '0;
         care_ff         <= '0;
         length_ff       <= LENGTH_W'(1);
         base_ff         <= '0;
         bytes_seen_ff   <= '0;
         phase_ff        <= '0;
         restart_ff      <= 1'b0;
         s1_valid_ff     <= 1'b0;
         match_count_ff  <= '0;
         first_offset_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         pattern_ff      <= pattern_in;
         care_ff         <= care_in;
         length_ff       <= length_in;
         base_ff         <= base_in;
         bytes_seen_ff   <= bytes_seen_in;
         phase_ff        <= phase_in;
         restart_ff      <= restart_in;
         s1_valid_ff     <= s1_valid_in;
         match_count_ff  <= match_count_in;
         first_offset_ff <= first_offset_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff     <= window_in;
      s1_last_ff    <= s1_last_in;
      s1_test_ff    <= s1_test_in;
      s1_taken_ff   <= s1_taken_in;
      s1_phase_ff   <= s1_phase_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_addr_ff, rsp_status_ff};

endmodule

`default_nettype wire

>>> rtl/core/mpus_checker.sv
`default_nettype none

module mpus_checker
   import mpus_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic [REQ_DATA_W-1:0]  req_tdata,
   input wire logic                   req_tlast,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_DATA_W-1:0]  rsp_tdata
);

   // A stalled result transaction keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result transaction changed");

   // Only a unique match carries an address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[STATUS_W-1:0] != STATUS_UNIQUE)
      |-> rsp_tdata[STATUS_W +: ADDR_W] == '0)
      else $error("address given without a unique match");

   // A result appears on an empty output after a final byte was taken and passed the compare-stage registers.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tlast, 2))
      else $error("result without a final byte");

   // Reset empties the output.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present after reset");

endmodule

bind masked_pattern_unique_scan mpus_checker u_checker (.*);

`default_nettype wire
